// File: rtl/letter_box_word_grouping_macros.svh
// Assertion macros for the letter box word grouping block.
// Used by the top level; expects clk and rst_n in scope.
`ifndef LETTER_BOX_WORD_GROUPING_MACROS_SVH
`define LETTER_BOX_WORD_GROUPING_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define LBWG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LBWG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lbwg_pkg.sv
// Shared types, constants and box arithmetic for letter box word grouping.
// No dependencies.
package lbwg_pkg;

    localparam int WORD_SLOTS  = 32;
    localparam int COORD_BITS  = 12;
    localparam int TOL_BITS    = 8;
    localparam int CFG_BITS    = (COORD_BITS > TOL_BITS) ? COORD_BITS : TOL_BITS;
    localparam int CFG_IDX_BITS = 3;
    localparam int SLOT_BITS   = (WORD_SLOTS > 1) ? $clog2(WORD_SLOTS) : 1;
    localparam int COUNT_BITS  = $clog2(WORD_SLOTS + 1);
    localparam int GAP_BITS    = COORD_BITS + 2;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_BITS  = 1;
    localparam int Q_CNT_BITS  = 2;

    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(WORD_SLOTS - 1);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [TOL_BITS-1:0]   tol_t;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_READ  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_REGION_XMIN = 3'd0,
        CFG_REGION_YMIN = 3'd1,
        CFG_REGION_XMAX = 3'd2,
        CFG_REGION_YMAX = 3'd3,
        CFG_MARGIN      = 3'd4,
        CFG_GAP_X       = 3'd5,
        CFG_GAP_Y       = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        B_IDLE = 2'd0,
        B_WALK = 2'd1,
        B_READ = 2'd2
    } back_state_t;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
    } box_t;

    typedef struct packed {
        action_t action;
        box_t    box;
    } cmd_t;

    typedef struct packed {
        coord_t region_xmin;
        coord_t region_ymin;
        coord_t region_xmax;
        coord_t region_ymax;
        tol_t   region_margin;
        tol_t   merge_gap_x;
        tol_t   merge_gap_y;
    } cfg_t;

    // [a0,a1] touches [b0,b1] widened by gap; signed, never wraps.
    function automatic logic near1d(coord_t a0, coord_t a1, coord_t b0, coord_t b1,
                                    tol_t gap);
        logic signed [GAP_BITS-1:0] lo;
        logic signed [GAP_BITS-1:0] hi;
        logic signed [GAP_BITS-1:0] sa0;
        logic signed [GAP_BITS-1:0] sa1;
        logic signed [GAP_BITS-1:0] sg;
        sg  = $signed({{(GAP_BITS-TOL_BITS){1'b0}}, gap});
        lo  = $signed({2'b00, b0}) - sg;
        hi  = $signed({2'b00, b1}) + sg;
        sa0 = $signed({2'b00, a0});
        sa1 = $signed({2'b00, a1});
        return !((sa1 < lo) || (sa0 > hi));
    endfunction

endpackage

// File: rtl/lbwg_front.sv
// Front end: accepts items, drops letters outside the region and unused codes.
// Depends on lbwg_pkg; feeds lbwg_queue.
module lbwg_front
    import lbwg_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] action,
    input  coord_t     letter_xmin,
    input  coord_t     letter_ymin,
    input  coord_t     letter_xmax,
    input  coord_t     letter_ymax,
    input  cfg_t       cfg,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_item
);

    logic in_region;
    logic keep;

    assign in_region =
        near1d(letter_xmin, letter_xmax, cfg.region_xmin, cfg.region_xmax,
               cfg.region_margin) &&
        near1d(letter_ymin, letter_ymax, cfg.region_ymin, cfg.region_ymax,
               cfg.region_margin);

    always_comb
    begin
        keep          = 1'b0;
        q_item.action = ACT_ADD;
        q_item.box    = '{x0: letter_xmin, y0: letter_ymin,
                          x1: letter_xmax, y1: letter_ymax};
        unique case (action)
            ACT_ADD:
            begin
                keep = in_region;
            end
            ACT_READ:
            begin
                keep          = 1'b1;
                q_item.action = ACT_READ;
            end
            ACT_CLEAR:
            begin
                keep          = 1'b1;
                q_item.action = ACT_CLEAR;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full && keep;

endmodule

// File: rtl/lbwg_queue.sv
// Two-entry command queue between front end and table engine.
// Depends on lbwg_pkg.
module lbwg_queue
    import lbwg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_item,
    input  logic pop,
    output cmd_t pop_item,
    output logic full,
    output logic empty
);

    cmd_t                  q_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_BITS-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == Q_CNT_BITS'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_item = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/lbwg_back.sv
// Table engine: walks the word table for letters, streams readouts, clears.
// Depends on lbwg_pkg; takes commands from lbwg_queue.
module lbwg_back
    import lbwg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic                  q_empty,
    input  cmd_t                  q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [SLOT_BITS-1:0]  slot_index,
    output coord_t                word_xmin,
    output coord_t                word_ymin,
    output coord_t                word_xmax,
    output coord_t                word_ymax,
    output logic                  word_valid,
    output logic [COUNT_BITS-1:0] word_count,
    output logic                  last
);

    box_t                  mem [WORD_SLOTS];
    logic [WORD_SLOTS-1:0] vld_reg;
    box_t                  rd_data_reg;
    logic                  rd_vld_reg;

    back_state_t           state_reg, state_next;
    logic [SLOT_BITS-1:0]  cur_reg, cur_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    box_t                  letter_reg, letter_next;

    logic                  out_valid_reg, out_valid_next;
    logic [SLOT_BITS-1:0]  out_slot_reg;
    box_t                  out_box_reg;
    logic                  out_wv_reg;
    logic [COUNT_BITS-1:0] out_count_reg;
    logic                  out_last_reg;

    box_t                  ent;
    box_t                  merged;
    box_t                  wr_data;
    logic                  wr_en;
    logic                  clr;
    logic                  load_out;
    logic                  slot_empty;
    logic                  slot_near;
    logic                  ent_valid;
    logic                  at_last;
    logic                  out_free;

    assign ent        = rd_vld_reg ? rd_data_reg : '0;
    assign slot_empty = (ent.x0 == '0) && (ent.x1 == '0);
    assign slot_near  = near1d(letter_reg.x0, letter_reg.x1, ent.x0, ent.x1, cfg.merge_gap_x) &&
                        near1d(letter_reg.y0, letter_reg.y1, ent.y0, ent.y1, cfg.merge_gap_y);
    assign ent_valid  = (ent.x1 > ent.x0) && (ent.y1 > ent.y0);
    assign at_last    = (cur_reg == SLOT_LAST);
    assign out_free   = !out_valid_reg || !out_stall;
    assign q_pop      = (state_reg == B_IDLE) && !q_empty;

    assign merged.x0 = (letter_reg.x0 < ent.x0) ? letter_reg.x0 : ent.x0;
    assign merged.y0 = (letter_reg.y0 < ent.y0) ? letter_reg.y0 : ent.y0;
    assign merged.x1 = (letter_reg.x1 > ent.x1) ? letter_reg.x1 : ent.x1;
    assign merged.y1 = (letter_reg.y1 > ent.y1) ? letter_reg.y1 : ent.y1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    if (q_item.action == ACT_ADD)
                    begin
                        state_next = B_WALK;
                    end
                    else if (q_item.action == ACT_READ)
                    begin
                        state_next = B_READ;
                    end
                end
            end
            B_WALK:
            begin
                if (slot_empty || slot_near || at_last)
                begin
                    state_next = B_IDLE;
                end
            end
            B_READ:
            begin
                if (out_free && at_last)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_next    = cur_reg;
        count_next  = count_reg;
        letter_next = letter_reg;
        wr_en       = 1'b0;
        wr_data     = letter_reg;
        clr         = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                cur_next = '0;
                if (q_pop)
                begin
                    letter_next = q_item.box;
                    count_next  = '0;
                    clr         = (q_item.action == ACT_CLEAR);
                end
            end
            B_WALK:
            begin
                if (slot_empty)
                begin
                    wr_en   = 1'b1;
                    wr_data = letter_reg;
                end
                else if (slot_near)
                begin
                    wr_en   = 1'b1;
                    wr_data = merged;
                end
                if (slot_empty || slot_near || at_last)
                begin
                    cur_next = '0;
                end
                else
                begin
                    cur_next = cur_reg + 1'b1;
                end
            end
            B_READ:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    count_next = count_reg + COUNT_BITS'(ent_valid);
                    cur_next   = at_last ? '0 : cur_reg + 1'b1;
                end
            end
            default:
            begin
                cur_next = '0;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    // Table memory: one write, one registered read at the next slot.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cur_reg] <= wr_data;
        end
        rd_data_reg <= mem[cur_next];
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_slot_reg  <= cur_reg;
            out_box_reg   <= ent;
            out_wv_reg    <= ent_valid;
            out_count_reg <= count_reg + COUNT_BITS'(ent_valid);
            out_last_reg  <= at_last;
        end
        letter_reg <= letter_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cur_reg       <= '0;
            count_reg     <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            rd_vld_reg    <= vld_reg[cur_next];
            if (clr)
            begin
                vld_reg <= '0;
            end
            else if (wr_en)
            begin
                vld_reg[cur_reg] <= 1'b1;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign slot_index = out_slot_reg;
    assign word_xmin  = out_box_reg.x0;
    assign word_ymin  = out_box_reg.y0;
    assign word_xmax  = out_box_reg.x1;
    assign word_ymax  = out_box_reg.y1;
    assign word_valid = out_wv_reg;
    assign word_count = out_count_reg;
    assign last       = out_last_reg;

endmodule

// File: rtl/letter_box_word_grouping.sv
// Letter box word grouping top level: config registers, front end, queue, table engine.
// Depends on lbwg_pkg, lbwg_front, lbwg_queue, lbwg_back and the assertion macro header.
//
// Input channel (in_valid / in_stall): one item per handshake, action plus a letter box.
//   Add: letter is kept only if it touches the region widened by the margin, then
//   merged into the first empty or nearby slot of the 32-slot word table.
//   Read: one output item per slot, slot 0 first, last set on the final slot.
//   Clear: empties the table. Action code 3 is taken and ignored.
// Output channel (out_valid / out_stall): a read item passes the queue and the table
//   engine, then readout items leave the output register one per cycle while out_stall
//   is low; a stall holds the current item and pauses the table scan.
// Table engine: serves one item at a time from a two-entry queue. Add walks the table
//   slot by slot through the table memory's single read port, read scans every slot
//   and pauses on stalls, clear needs no walk.
// Config: cfg_we writes register cfg_index with cfg_data; write only while idle.
// Reset: asynchronous, active low; the table reads as empty and registers take their
//   defaults (region 0..4095, margin 20, gaps 60 and 5).
`include "letter_box_word_grouping_macros.svh"

module letter_box_word_grouping
    import lbwg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              action,
    input  coord_t                  letter_xmin,
    input  coord_t                  letter_ymin,
    input  coord_t                  letter_xmax,
    input  coord_t                  letter_ymax,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SLOT_BITS-1:0]    slot_index,
    output coord_t                  word_xmin,
    output coord_t                  word_ymin,
    output coord_t                  word_xmax,
    output coord_t                  word_ymax,
    output logic                    word_valid,
    output logic [COUNT_BITS-1:0]   word_count,
    output logic                    last
);

    cfg_t cfg_reg, cfg_next;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t push_item;
    cmd_t pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REGION_XMIN: cfg_next.region_xmin   = cfg_data[COORD_BITS-1:0];
                CFG_REGION_YMIN: cfg_next.region_ymin   = cfg_data[COORD_BITS-1:0];
                CFG_REGION_XMAX: cfg_next.region_xmax   = cfg_data[COORD_BITS-1:0];
                CFG_REGION_YMAX: cfg_next.region_ymax   = cfg_data[COORD_BITS-1:0];
                CFG_MARGIN:      cfg_next.region_margin = cfg_data[TOL_BITS-1:0];
                CFG_GAP_X:       cfg_next.merge_gap_x   = cfg_data[TOL_BITS-1:0];
                CFG_GAP_Y:       cfg_next.merge_gap_y   = cfg_data[TOL_BITS-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_xmin   <= COORD_BITS'(0);
            cfg_reg.region_ymin   <= COORD_BITS'(0);
            cfg_reg.region_xmax   <= COORD_BITS'(4095);
            cfg_reg.region_ymax   <= COORD_BITS'(4095);
            cfg_reg.region_margin <= TOL_BITS'(20);
            cfg_reg.merge_gap_x   <= TOL_BITS'(60);
            cfg_reg.merge_gap_y   <= TOL_BITS'(5);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lbwg_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .letter_xmin (letter_xmin),
        .letter_ymin (letter_ymin),
        .letter_xmax (letter_xmax),
        .letter_ymax (letter_ymax),
        .cfg         (cfg_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (push_item)
    );

    lbwg_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    lbwg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_item     (pop_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .slot_index (slot_index),
        .word_xmin  (word_xmin),
        .word_ymin  (word_ymin),
        .word_xmax  (word_xmax),
        .word_ymax  (word_ymax),
        .word_valid (word_valid),
        .word_count (word_count),
        .last       (last)
    );

    `LBWG_ASSERT_NOW(a_last_on_final_slot, out_valid && last, slot_index == SLOT_LAST, "last on wrong slot")
    `LBWG_ASSERT_NOW(a_count_bound, out_valid, word_count <= COUNT_BITS'(slot_index) + COUNT_BITS'(1), "word count too large")
    `LBWG_ASSERT_NEXT(a_readout_streams, out_valid && !out_stall && !last, out_valid, "readout gap")

endmodule

// File: dv/word_table_checker.sv
`timescale 1ns / 100ps
// Watches both channels and the register port of letter_box_word_grouping. It keeps its own
// word table, predicts every readout item and compares it. Depends on lbwg_pkg.
module word_table_checker
    import lbwg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic [1:0]              action,
    input  coord_t                  letter_xmin,
    input  coord_t                  letter_ymin,
    input  coord_t                  letter_xmax,
    input  coord_t                  letter_ymax,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [SLOT_BITS-1:0]    slot_index,
    input  coord_t                  word_xmin,
    input  coord_t                  word_ymin,
    input  coord_t                  word_xmax,
    input  coord_t                  word_ymax,
    input  logic                    word_valid,
    input  logic [COUNT_BITS-1:0]   word_count,
    input  logic                    last,
    output int                      mismatches,
    output int                      words_pending
);

    typedef struct packed {
        logic [SLOT_BITS-1:0]  slot;
        coord_t                x0;
        coord_t                y0;
        coord_t                x1;
        coord_t                y1;
        logic                  valid;
        logic [COUNT_BITS-1:0] count;
        logic                  last;
    } word_report_t;

    localparam cfg_t REGS_AT_RESET = '{
        region_xmin: 12'd0, region_ymin: 12'd0,
        region_xmax: 12'd4095, region_ymax: 12'd4095,
        region_margin: 8'd20, merge_gap_x: 8'd60, merge_gap_y: 8'd5
    };

    box_t         words [WORD_SLOTS];
    cfg_t         regs;
    word_report_t words_due [$];

    // interval [a0,a1] touches [b0,b1] widened by gap, exact signed compare
    function automatic bit spans_touch(int a0, int a1, int b0, int b1, int gap);
        return !((a1 < b0 - gap) || (a0 > b1 + gap));
    endfunction

    function automatic void file_letter(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
        if (!spans_touch(int'(x0), int'(x1), int'(regs.region_xmin),
                         int'(regs.region_xmax), int'(regs.region_margin)) ||
            !spans_touch(int'(y0), int'(y1), int'(regs.region_ymin),
                         int'(regs.region_ymax), int'(regs.region_margin)))
            return;
        for (int s = 0; s < WORD_SLOTS; s++)
        begin
            if (words[s].x0 == '0 && words[s].x1 == '0)
            begin
                words[s] = '{x0, y0, x1, y1};
                return;
            end
            if (spans_touch(int'(x0), int'(x1), int'(words[s].x0), int'(words[s].x1),
                            int'(regs.merge_gap_x)) &&
                spans_touch(int'(y0), int'(y1), int'(words[s].y0), int'(words[s].y1),
                            int'(regs.merge_gap_y)))
            begin
                if (x0 < words[s].x0) words[s].x0 = x0;
                if (y0 < words[s].y0) words[s].y0 = y0;
                if (x1 > words[s].x1) words[s].x1 = x1;
                if (y1 > words[s].y1) words[s].y1 = y1;
                return;
            end
        end
        // table full: letter lost
    endfunction

    function automatic void emit_readout();
        word_report_t r;
        int           count;
        count = 0;
        for (int s = 0; s < WORD_SLOTS; s++)
        begin
            r.slot  = SLOT_BITS'(s);
            r.x0    = words[s].x0;
            r.y0    = words[s].y0;
            r.x1    = words[s].x1;
            r.y1    = words[s].y1;
            r.valid = (words[s].x1 > words[s].x0) && (words[s].y1 > words[s].y0);
            count   = count + int'(r.valid);
            r.count = COUNT_BITS'(count);
            r.last  = (s == WORD_SLOTS - 1);
            words_due.push_back(r);
        end
    endfunction

    function automatic void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        case (idx)
            CFG_REGION_XMIN: regs.region_xmin   = data[COORD_BITS-1:0];
            CFG_REGION_YMIN: regs.region_ymin   = data[COORD_BITS-1:0];
            CFG_REGION_XMAX: regs.region_xmax   = data[COORD_BITS-1:0];
            CFG_REGION_YMAX: regs.region_ymax   = data[COORD_BITS-1:0];
            CFG_MARGIN:      regs.region_margin = data[TOL_BITS-1:0];
            CFG_GAP_X:       regs.merge_gap_x   = data[TOL_BITS-1:0];
            CFG_GAP_Y:       regs.merge_gap_y   = data[TOL_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_report_t r;
        if (!rst_n)
        begin
            foreach (words[s]) words[s] = '0;
            regs = REGS_AT_RESET;
            words_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (words_due.size() == 0)
                begin
                    $error("readout item at slot %0d with none expected", slot_index);
                    mismatches++;
                end
                else
                begin
                    r = words_due.pop_front();
                    check_field("slot_index", 16'(r.slot), 16'(slot_index));
                    check_field("word_xmin", 16'(r.x0), 16'(word_xmin));
                    check_field("word_ymin", 16'(r.y0), 16'(word_ymin));
                    check_field("word_xmax", 16'(r.x1), 16'(word_xmax));
                    check_field("word_ymax", 16'(r.y1), 16'(word_ymax));
                    check_field("word_valid", 16'(r.valid), 16'(word_valid));
                    check_field("word_count", 16'(r.count), 16'(word_count));
                    check_field("last", 16'(r.last), 16'(last));
                end
            end
            if (cfg_we)
                write_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
            begin
                case (action)
                    ACT_ADD:   file_letter(letter_xmin, letter_ymin, letter_xmax, letter_ymax);
                    ACT_READ:  emit_readout();
                    ACT_CLEAR: foreach (words[s]) words[s] = '0;
                    default: ;
                endcase
            end
        end
        words_pending = words_due.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Top of the letter_box_word_grouping bench: clock, reset, stimulus, receiver stalls, verdict.
// Depends on lbwg_pkg, the block's RTL and word_table_checker.
module testbench;
    import lbwg_pkg::*;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         DRAIN_CYCLES = 120;
    localparam int         HOLD_CYCLES  = 300;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [1:0]              action;
    coord_t                  letter_xmin;
    coord_t                  letter_ymin;
    coord_t                  letter_xmax;
    coord_t                  letter_ymax;
    logic                    out_valid;
    logic                    out_stall;
    logic [SLOT_BITS-1:0]    slot_index;
    coord_t                  word_xmin;
    coord_t                  word_ymin;
    coord_t                  word_xmax;
    coord_t                  word_ymax;
    logic                    word_valid;
    logic [COUNT_BITS-1:0]   word_count;
    logic                    last;
    int                      mismatches;
    int                      words_pending;
    bit                      pressure_go = 1'b0;
    int                      burst_left = 0;

    letter_box_word_grouping dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .action(action),
        .letter_xmin(letter_xmin), .letter_ymin(letter_ymin),
        .letter_xmax(letter_xmax), .letter_ymax(letter_ymax),
        .out_valid(out_valid), .out_stall(out_stall), .slot_index(slot_index),
        .word_xmin(word_xmin), .word_ymin(word_ymin),
        .word_xmax(word_xmax), .word_ymax(word_ymax),
        .word_valid(word_valid), .word_count(word_count), .last(last)
    );

    word_table_checker word_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .action(action),
        .letter_xmin(letter_xmin), .letter_ymin(letter_ymin),
        .letter_xmax(letter_xmax), .letter_ymax(letter_ymax),
        .out_valid(out_valid), .out_stall(out_stall), .slot_index(slot_index),
        .word_xmin(word_xmin), .word_ymin(word_ymin),
        .word_xmax(word_xmax), .word_ymax(word_ymax),
        .word_valid(word_valid), .word_count(word_count), .last(last),
        .mismatches(mismatches), .words_pending(words_pending)
    );

    always #5 clk = ~clk;

    function automatic coord_t any_coord();
        return coord_t'($urandom_range(0, 4095));
    endfunction

    function automatic tol_t pick_tol();
        case ($urandom_range(0, 2))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return tol_t'($urandom_range(0, 255));
        endcase
    endfunction

    // one item; sender sometimes idles between bursts of random length
    task automatic offer(input logic [1:0] act, input coord_t x0, input coord_t y0,
                         input coord_t x1, input coord_t y1);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid    <= 1'b1;
        action      <= act;
        letter_xmin <= x0;
        letter_ymin <= y0;
        letter_xmax <= x1;
        letter_ymax <= y1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
    endtask

    task automatic offer_read();
        offer(ACT_READ, any_coord(), any_coord(), any_coord(), any_coord());
    endtask

    task automatic offer_spread_letter();
        coord_t x0;
        coord_t y0;
        x0 = coord_t'($urandom_range(1, 4070));
        y0 = coord_t'($urandom_range(0, 4070));
        offer(ACT_ADD, x0, y0, x0 + coord_t'($urandom_range(1, 20)),
              y0 + coord_t'($urandom_range(1, 20)));
    endtask

    // wait until every readout item is in, then let the table engine finish
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input logic [CFG_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_regs(input coord_t rx0, input coord_t ry0, input coord_t rx1,
                                input coord_t ry1, input tol_t margin, input tol_t gx,
                                input tol_t gy);
        settle();
        put_reg(CFG_REGION_XMIN, CFG_BITS'(rx0));
        put_reg(CFG_REGION_YMIN, CFG_BITS'(ry0));
        put_reg(CFG_REGION_XMAX, CFG_BITS'(rx1));
        put_reg(CFG_REGION_YMAX, CFG_BITS'(ry1));
        put_reg(CFG_MARGIN, CFG_BITS'(margin));
        put_reg(CFG_GAP_X, CFG_BITS'(gx));
        put_reg(CFG_GAP_Y, CFG_BITS'(gy));
        cfg_we <= 1'b0;
    endtask

    task automatic program_random_regs();
        coord_t a;
        coord_t b;
        coord_t c;
        coord_t d;
        a = any_coord();
        b = any_coord();
        c = any_coord();
        d = any_coord();
        case ($urandom_range(0, 3))
            0: program_regs(12'd0, 12'd0, 12'd4095, 12'd4095, pick_tol(), pick_tol(), pick_tol());
            1: program_regs(a < b ? a : b, c < d ? c : d, a < b ? b : a, c < d ? d : c,
                            pick_tol(), pick_tol(), pick_tol());
            2: program_regs(a < b ? b : a, c < d ? d : c, a < b ? a : b, c < d ? c : d,
                            pick_tol(), pick_tol(), pick_tol());
            default: program_regs(a, c, b, d, pick_tol(), pick_tol(), pick_tol());
        endcase
    endtask

    // mostly letters around a few word rows, plus reads, clears, noise
    task automatic run_phase(input int n_items);
        coord_t ax [4];
        coord_t ay [4];
        coord_t x0;
        coord_t y0;
        int     k;
        int     r;
        foreach (ax[i])
        begin
            ax[i] = coord_t'($urandom_range(0, 3800));
            ay[i] = coord_t'($urandom_range(0, 4000));
        end
        repeat (n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                offer_read();
            else if (r < 10)
                offer(ACT_CLEAR, any_coord(), any_coord(), any_coord(), any_coord());
            else if (r < 13)
                offer(ACT_UNUSED, any_coord(), any_coord(), any_coord(), any_coord());
            else if (r < 20)
                offer(ACT_ADD, any_coord(), any_coord(), any_coord(), any_coord());
            else if (r < 24)
                offer(ACT_ADD, 12'd0, any_coord(), 12'd0, any_coord());
            else if (r < 32)
                offer_spread_letter();
            else
            begin
                k  = $urandom_range(0, 3);
                x0 = ax[k] + coord_t'($urandom_range(0, 250));
                y0 = ay[k] + coord_t'($urandom_range(0, 10));
                offer(ACT_ADD, x0, y0, x0 + coord_t'($urandom_range(2, 30)),
                      y0 + coord_t'($urandom_range(8, 40)));
            end
        end
        offer_read();
    endtask

    // receiver: own stall pattern, one long hold-off once the sender asks for pressure
    initial
    begin : receiver
        bit   held;
        int   run;
        logic hold;
        out_stall = 1'b0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (pressure_go && !held)
            begin
                hold = 1'b1;
                run  = HOLD_CYCLES;
                held = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        hold = 1'b0;
                        run  = $urandom_range(5, 40);
                    end
                    1, 2:
                    begin
                        hold = $urandom_range(0, 1);
                        run  = $urandom_range(1, 3);
                    end
                    default:
                    begin
                        hold = 1'b1;
                        run  = $urandom_range(1, 8);
                    end
                endcase
            end
            out_stall <= hold;
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        action      = ACT_ADD;
        letter_xmin = '0;
        letter_ymin = '0;
        letter_xmax = '0;
        letter_ymax = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: empty readout, merge, extremes, holes, skipped later slot
        offer_read();
        offer(ACT_ADD, 12'd100, 12'd100, 12'd110, 12'd120);
        offer(ACT_ADD, 12'd150, 12'd102, 12'd160, 12'd118);
        offer(ACT_ADD, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        offer(ACT_ADD, 12'd0, 12'd0, 12'd0, 12'd5);
        offer(ACT_ADD, 12'd300, 12'd300, 12'd310, 12'd310);
        offer(ACT_ADD, 12'd5, 12'd600, 12'd0, 12'd610);
        offer(ACT_ADD, 12'd1000, 12'd1000, 12'd1010, 12'd1010);
        offer(ACT_ADD, 12'd0, 12'd600, 12'd0, 12'd610);
        offer(ACT_ADD, 12'd1005, 12'd1000, 12'd1008, 12'd1010);
        offer(ACT_UNUSED, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        offer_read();
        offer(ACT_CLEAR, 12'd0, 12'd0, 12'd0, 12'd0);
        offer_read();

        // tight region, no margin, no merge tolerance
        program_regs(12'd1000, 12'd1000, 12'd1100, 12'd1100, 8'd0, 8'd0, 8'd0);
        offer(ACT_ADD, 12'd900, 12'd1050, 12'd999, 12'd1060);
        offer(ACT_ADD, 12'd900, 12'd1050, 12'd1000, 12'd1060);
        offer(ACT_ADD, 12'd1100, 12'd1000, 12'd1200, 12'd1000);
        offer(ACT_ADD, 12'd1050, 12'd1101, 12'd1060, 12'd1200);
        offer_read();

        // widest tolerances: widened edges below zero and past the range
        program_regs(12'd0, 12'd0, 12'd4095, 12'd4095, 8'd255, 8'd255, 8'd255);
        offer(ACT_CLEAR, 12'd0, 12'd0, 12'd0, 12'd0);
        offer(ACT_ADD, 12'd10, 12'd10, 12'd20, 12'd20);
        offer(ACT_ADD, 12'd0, 12'd0, 12'd0, 12'd0);
        offer(ACT_ADD, 12'd3900, 12'd3900, 12'd3950, 12'd3950);
        offer(ACT_ADD, 12'd4095, 12'd4095, 12'd4095, 12'd4095);
        offer_read();

        program_random_regs();
        run_phase(10);

        // reads pile up behind the long hold-off
        pressure_go = 1'b1;
        repeat (4) offer_read();
        run_phase(10);

        // fill the table, then lose letters
        program_regs(12'd0, 12'd0, 12'd4095, 12'd4095, 8'd0, 8'd0, 8'd0);
        offer(ACT_CLEAR, 12'd0, 12'd0, 12'd0, 12'd0);
        repeat (40) offer_spread_letter();
        offer_read();
        repeat (3) offer_spread_letter();
        offer_read();

        program_random_regs();
        run_phase(10);

        settle();
        if (mismatches == 0 && words_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/lbwg_pkg.sv
rtl/lbwg_front.sv
rtl/lbwg_queue.sv
rtl/lbwg_back.sv
rtl/letter_box_word_grouping.sv
dv/word_table_checker.sv
dv/testbench.sv
